// ===== hw/rtl/sad_tm_pkg.sv =====
// Shared types and constants for the SAD template matcher.
// No dependencies; imported by the walker, the accumulator, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sad_tm_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_IMAGE  = 2'd0,
    REQ_TMPL   = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  localparam int unsigned SadW = 28;
  localparam logic [SadW-1:0] SadMax = {SadW{1'b1}};

  // Flags that travel with each element read through the pipeline.
  typedef struct packed {
    logic valid;  // an element pair is in flight
    logic first;  // first element of a placement
    logic last;   // last element of a placement
    logic fin;    // last element of the last placement
  } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sad_tm_store.sv =====
// Image and template element memories: one write port and one registered read port each.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module sad_tm_store #(
  parameter int unsigned Depth  = 4096,
  parameter int unsigned ValueW = 16,
  parameter int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              img_we_i,
  input  wire logic              tmp_we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [ValueW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  img_raddr_i,
  input  wire logic [AddrW-1:0]  tmp_raddr_i,
  output logic      [ValueW-1:0] img_rdata_o,
  output logic      [ValueW-1:0] tmp_rdata_o
);

  logic [ValueW-1:0] img_mem [Depth];
  logic [ValueW-1:0] tmp_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (img_we_i) begin
      img_mem[waddr_i] <= wdata_i;
    end
    img_rdata_o <= img_mem[img_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (tmp_we_i) begin
      tmp_mem[waddr_i] <= wdata_i;
    end
    tmp_rdata_o <= tmp_mem[tmp_raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sad_tm_walk.sv =====
// Placement walker: steps through every placement and every template element,
// issuing one image and one template read a cycle. Depends on sad_tm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sad_tm_walk #(
  parameter int unsigned MaxRows = 64,
  parameter int unsigned MaxCols = 64,
  parameter int unsigned RowW    = (MaxRows > 1) ? $clog2(MaxRows) : 1,
  parameter int unsigned ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  parameter int unsigned RowSzW  = $clog2(MaxRows + 1),
  parameter int unsigned ColSzW  = $clog2(MaxCols + 1),
  parameter int unsigned AddrW   = (MaxRows * MaxCols > 1) ? $clog2(MaxRows * MaxCols) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RowSzW-1:0] ir_i,
  input  wire logic [ColSzW-1:0] ic_i,
  input  wire logic [RowSzW-1:0] tr_i,
  input  wire logic [ColSzW-1:0] tc_i,
  output logic      [AddrW-1:0]  img_addr_o,
  output logic      [AddrW-1:0]  tmp_addr_o,
  output sad_tm_pkg::tag_t       tag_o,
  output logic      [RowW-1:0]   pos_row_o,
  output logic      [ColW-1:0]   pos_col_o
);

  import sad_tm_pkg::*;

  localparam logic [AddrW-1:0] ColsK = AddrW'(MaxCols);

  logic            run_q, run_d;
  logic [RowW-1:0] i_q, i_d, x_q, x_d, lim_i_q, lim_i_d, tr_m1_q, tr_m1_d;
  logic [ColW-1:0] j_q, j_d, y_q, y_d, lim_j_q, lim_j_d, tc_m1_q, tc_m1_d;
  logic [RowW:0]   img_row;
  logic [ColW:0]   img_col;
  logic            y_end, x_end, j_end, i_end;

  assign y_end = (y_q == tc_m1_q);
  assign x_end = (x_q == tr_m1_q);
  assign j_end = (j_q == lim_j_q);
  assign i_end = (i_q == lim_i_q);

  always_comb begin
    run_d   = run_q;
    i_d     = i_q;
    j_d     = j_q;
    x_d     = x_q;
    y_d     = y_q;
    lim_i_d = lim_i_q;
    lim_j_d = lim_j_q;
    tr_m1_d = tr_m1_q;
    tc_m1_d = tc_m1_q;
    if (start_i) begin
      run_d   = 1'b1;
      i_d     = '0;
      j_d     = '0;
      x_d     = '0;
      y_d     = '0;
      lim_i_d = RowW'(ir_i - tr_i);
      lim_j_d = ColW'(ic_i - tc_i);
      tr_m1_d = RowW'(tr_i - RowSzW'(1));
      tc_m1_d = ColW'(tc_i - ColSzW'(1));
    end else if (run_q) begin
      if (!y_end) begin
        y_d = y_q + ColW'(1);
      end else begin
        y_d = '0;
        if (!x_end) begin
          x_d = x_q + RowW'(1);
        end else begin
          x_d = '0;
          if (!j_end) begin
            j_d = j_q + ColW'(1);
          end else begin
            j_d = '0;
            if (!i_end) begin
              i_d = i_q + RowW'(1);
            end else begin
              run_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      lim_i_q <= '0;
      lim_j_q <= '0;
      tr_m1_q <= '0;
      tc_m1_q <= '0;
    end else begin
      run_q   <= run_d;
      i_q     <= i_d;
      j_q     <= j_d;
      x_q     <= x_d;
      y_q     <= y_d;
      lim_i_q <= lim_i_d;
      lim_j_q <= lim_j_d;
      tr_m1_q <= tr_m1_d;
      tc_m1_q <= tc_m1_d;
    end
  end

  assign img_row = {1'b0, i_q} + {1'b0, x_q};
  assign img_col = {1'b0, j_q} + {1'b0, y_q};

  assign img_addr_o = AddrW'(img_row) * ColsK + AddrW'(img_col);
  assign tmp_addr_o = AddrW'(x_q) * ColsK + AddrW'(y_q);

  assign tag_o.valid = run_q;
  assign tag_o.first = (x_q == '0) && (y_q == '0);
  assign tag_o.last  = x_end && y_end;
  assign tag_o.fin   = x_end && y_end && j_end && i_end;
  assign pos_row_o   = i_q;
  assign pos_col_o   = j_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sad_tm_accum.sv =====
// Difference, accumulate and best-placement stages behind the element memories.
// Depends on sad_tm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sad_tm_accum #(
  parameter int unsigned ValueW = 16,
  parameter int unsigned RowW   = 6,
  parameter int unsigned ColW   = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire sad_tm_pkg::tag_t        tag_i,
  input  wire logic [RowW-1:0]         pos_row_i,
  input  wire logic [ColW-1:0]         pos_col_i,
  input  wire logic [ValueW-1:0]       img_rdata_i,
  input  wire logic [ValueW-1:0]       tmp_rdata_i,
  output logic                         done_o,
  output logic [RowW-1:0]              best_row_o,
  output logic [ColW-1:0]              best_col_o,
  output logic [sad_tm_pkg::SadW-1:0]  best_sad_o
);

  import sad_tm_pkg::*;

  localparam int unsigned DiffW = ValueW + 1;
  localparam int unsigned AccW  = ((DiffW > SadW) ? DiffW : SadW) + 1;

  tag_t            tag1_q, tag2_q, tag3_q;
  logic [RowW-1:0] row1_q, row2_q, row3_q;
  logic [ColW-1:0] col1_q, col2_q, col3_q;

  logic signed [DiffW-1:0] diff_s;
  logic        [DiffW-1:0] diff_d, diff_q;
  logic        [AccW-1:0]  sum;
  logic        [SadW-1:0]  acc_d, acc_q;
  logic                    have_q, done_q;
  logic        [SadW-1:0]  best_q;
  logic        [RowW-1:0]  brow_q;
  logic        [ColW-1:0]  bcol_q;

  // Stage 1 lines the tags up with the registered memory data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q <= pos_row_i;
    col1_q <= pos_col_i;
    row2_q <= row1_q;
    col2_q <= col1_q;
    row3_q <= row2_q;
    col3_q <= col2_q;
  end

  // Stage 2: absolute difference of the two signed elements.
  always_comb begin
    diff_s = $signed({img_rdata_i[ValueW-1], img_rdata_i})
           - $signed({tmp_rdata_i[ValueW-1], tmp_rdata_i});
    diff_d = diff_s[DiffW-1] ? DiffW'(-diff_s) : DiffW'(diff_s);
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // Stage 3: running sum, saturating; partial sums only grow.
  always_comb begin
    sum   = (tag2_q.first ? '0 : AccW'(acc_q)) + AccW'(diff_q);
    acc_d = (sum > AccW'(SadMax)) ? SadMax : SadW'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // Stage 4: keep the first placement with the strictly smallest sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= tag3_q.valid && tag3_q.fin;
      if (start_i) begin
        have_q <= 1'b0;
      end else if (tag3_q.valid && tag3_q.last) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag3_q.valid && tag3_q.last && (!have_q || (acc_q < best_q))) begin
      best_q <= acc_q;
      brow_q <= row3_q;
      bcol_q <= col3_q;
    end
  end

  assign done_o     = done_q;
  assign best_row_o = brow_q;
  assign best_col_o = bcol_q;
  assign best_sad_o = best_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sad_template_match.sv =====
// Top level of the SAD template matcher: stream ports, size registers, control and result register.
// Depends on sad_tm_pkg, sad_tm_store, sad_tm_walk and sad_tm_accum.
//
// Usage. Items enter on the s_axis group; tuser gives the kind of request. An image or template
// write stores one element at its row and column and is taken back to back with other writes,
// with no result. Rows or columns outside the store are dropped. A search walks the template over
// every placement in raster order and returns one item on the m_axis group: the first placement
// with the smallest sum of absolute differences and that sum, or found low with zero fields when
// the template does not fit inside the image.
// The size registers are written through cfg_we_i / cfg_index_i / cfg_data_i; a size of zero
// counts as one and a size above the store limit counts as that limit.
// Timing. A search that fits walks every placement and every template element in turn, reading
// one image and one template element a cycle from the element memories; each sum then passes
// through the read, difference, accumulate and compare stages and the result load before its
// result is offered. A search with no placement goes straight to the result load.
// s_axis_tready is low for the whole search, and longer while an earlier result still waits in
// the output register.
// Reset clears the control state and the size registers to one; the memories keep whatever
// they held. A result waits in the output register while the receiver stalls; writes are still
// taken then, but a further search result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module sad_template_match #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // elem_row[5:0], elem_col[11:6], elem_value[27:12]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // best_row[5:0], best_col[11:6], best_sad[39:12]
  output logic             m_axis_tuser,   // found[0]
  // Size registers: 0 image_rows, 1 image_cols, 2 tmpl_rows, 3 tmpl_cols.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);

  import sad_tm_pkg::*;

  localparam int unsigned Depth  = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowSzW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColSzW = $clog2(MAX_COLS + 1);
  localparam logic [AddrW-1:0] ColsK = AddrW'(MAX_COLS);

  localparam logic [1:0] CFG_IMG_ROWS = 2'd0;
  localparam logic [1:0] CFG_IMG_COLS = 2'd1;
  localparam logic [1:0] CFG_TPL_ROWS = 2'd2;
  localparam logic [1:0] CFG_TPL_COLS = 2'd3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Input fields.
  logic [5:0]  elem_row;
  logic [5:0]  elem_col;
  logic [15:0] elem_value;
  assign elem_row   = s_axis_tdata[5:0];
  assign elem_col   = s_axis_tdata[11:6];
  assign elem_value = s_axis_tdata[27:12];

  // Size registers as written.
  logic [6:0] img_rows_q, img_cols_q, tpl_rows_q, tpl_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_rows_q <= 7'd1;
      img_cols_q <= 7'd1;
      tpl_rows_q <= 7'd1;
      tpl_cols_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMG_ROWS: img_rows_q <= cfg_data_i;
        CFG_IMG_COLS: img_cols_q <= cfg_data_i;
        CFG_TPL_ROWS: tpl_rows_q <= cfg_data_i;
        CFG_TPL_COLS: tpl_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes in use: zero counts as one, anything beyond the store as its limit.
  logic [RowSzW-1:0] ir_c, tr_c;
  logic [ColSzW-1:0] ic_c, tc_c;
  logic              fits;

  always_comb begin
    ir_c = (img_rows_q == 7'd0) ? RowSzW'(1) :
           (32'(img_rows_q) > MAX_ROWS) ? RowSzW'(MAX_ROWS) : RowSzW'(img_rows_q);
    tr_c = (tpl_rows_q == 7'd0) ? RowSzW'(1) :
           (32'(tpl_rows_q) > MAX_ROWS) ? RowSzW'(MAX_ROWS) : RowSzW'(tpl_rows_q);
    ic_c = (img_cols_q == 7'd0) ? ColSzW'(1) :
           (32'(img_cols_q) > MAX_COLS) ? ColSzW'(MAX_COLS) : ColSzW'(img_cols_q);
    tc_c = (tpl_cols_q == 7'd0) ? ColSzW'(1) :
           (32'(tpl_cols_q) > MAX_COLS) ? ColSzW'(MAX_COLS) : ColSzW'(tpl_cols_q);
    fits = (tr_c <= ir_c) && (tc_c <= ic_c);
  end

  // Control.
  logic [1:0] state_q, state_d;
  logic       fits_q, fits_d;
  logic       s_hs, in_range, is_search, start;
  logic       img_we, tmp_we, out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(elem_row) < MAX_ROWS) && (32'(elem_col) < MAX_COLS);
  assign is_search     = (s_axis_tuser == REQ_SEARCH);
  assign img_we        = s_hs && (s_axis_tuser == REQ_IMAGE) && in_range;
  assign tmp_we        = s_hs && (s_axis_tuser == REQ_TMPL) && in_range;
  assign start         = s_hs && is_search && fits;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  logic [AddrW-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  assign waddr = AddrW'(elem_row) * ColsK + AddrW'(elem_col);
  assign wdata = VALUE_BITS'($signed(elem_value));

  logic                    acc_done;
  logic [RowW-1:0]         best_row;
  logic [ColW-1:0]         best_col;
  logic [SadW-1:0]         best_sad;

  always_comb begin
    state_d = state_q;
    fits_d  = fits_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs && is_search) begin
          fits_d  = fits;
          state_d = fits ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (acc_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fits_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fits_q  <= fits_d;
    end
  end

  // Output register: loaded as the search ends and the slot is free.
  logic        out_valid_q;
  logic        found_q;
  logic [5:0]  row_q, col_q;
  logic [SadW-1:0] sad_q;
  logic        load;

  assign load = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= fits_q;
      row_q   <= fits_q ? 6'(best_row) : 6'd0;
      col_q   <= fits_q ? 6'(best_col) : 6'd0;
      sad_q   <= fits_q ? best_sad : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {sad_q, col_q, row_q};
  assign m_axis_tuser  = found_q;

  // Datapath.
  logic [AddrW-1:0]      img_raddr, tmp_raddr;
  logic [VALUE_BITS-1:0] img_rdata, tmp_rdata;
  tag_t                  tag;
  logic [RowW-1:0]       pos_row;
  logic [ColW-1:0]       pos_col;

  sad_tm_store #(
    .Depth  (Depth),
    .ValueW (VALUE_BITS),
    .AddrW  (AddrW)
  ) u_store (
    .clk_i       (clk_i),
    .img_we_i    (img_we),
    .tmp_we_i    (tmp_we),
    .waddr_i     (waddr),
    .wdata_i     (wdata),
    .img_raddr_i (img_raddr),
    .tmp_raddr_i (tmp_raddr),
    .img_rdata_o (img_rdata),
    .tmp_rdata_o (tmp_rdata)
  );

  sad_tm_walk #(
    .MaxRows (MAX_ROWS),
    .MaxCols (MAX_COLS),
    .RowW    (RowW),
    .ColW    (ColW),
    .RowSzW  (RowSzW),
    .ColSzW  (ColSzW),
    .AddrW   (AddrW)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .ir_i       (ir_c),
    .ic_i       (ic_c),
    .tr_i       (tr_c),
    .tc_i       (tc_c),
    .img_addr_o (img_raddr),
    .tmp_addr_o (tmp_raddr),
    .tag_o      (tag),
    .pos_row_o  (pos_row),
    .pos_col_o  (pos_col)
  );

  sad_tm_accum #(
    .ValueW (VALUE_BITS),
    .RowW   (RowW),
    .ColW   (ColW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .tag_i       (tag),
    .pos_row_i   (pos_row),
    .pos_col_i   (pos_col),
    .img_rdata_i (img_rdata),
    .tmp_rdata_i (tmp_rdata),
    .done_o      (acc_done),
    .best_row_o  (best_row),
    .best_col_o  (best_col),
    .best_sad_o  (best_sad)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sad_tm_checker.sv =====
// Port-level checks for the SAD template matcher, bound to the top level.
// Depends on sad_tm_pkg and sad_template_match.
`timescale 1ns / 1ps
`default_nettype none

module sad_tm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  import sad_tm_pkg::*;

  // No result is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  // A stalled result holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With no placement every result field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("non-zero fields without a placement");

  // Once a search is taken, s_axis_tready goes low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_SEARCH) |=> !s_axis_tready)
    else $error("item taken during a search");

endmodule

bind sad_template_match sad_tm_checker u_sad_tm_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for sad_template_match: element loads, searches and size settings.
// Needs the package sad_tm_pkg and the top level of the block; expected matches come from a
// behavioural search kept inside the scoreboard class below.
`timescale 1ns / 1ps

module tb_top;
  import sad_tm_pkg::*;

  localparam int HALF_PERIOD_NS = 1;
  localparam int STORE_DIM      = 64;
  localparam int STORE_CELLS    = STORE_DIM * STORE_DIM;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 20000;

  // Request code that the block does not know and must drop.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Size register indexes.
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLS = 2'd1;
  localparam logic [1:0] REG_TMPL_ROWS  = 2'd2;
  localparam logic [1:0] REG_TMPL_COLS  = 2'd3;

  typedef struct packed {
    logic [1:0]         req;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } elem_item_t;

  typedef struct packed {
    logic            found;
    logic [5:0]      row;
    logic [5:0]      col;
    logic [SadW-1:0] sad;
  } match_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;

  always #(HALF_PERIOD_NS) clk_i = ~clk_i;

  sad_template_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Holds its own copy of both stores and the size registers, and the matches still owed.
  class match_checker;
    shortint     image_cells [STORE_CELLS];
    shortint     tmpl_cells  [STORE_CELLS];
    logic [6:0]  sizes [4];
    match_t      pending_matches [$];
    int unsigned errors;

    function new();
      foreach (image_cells[k]) begin
        image_cells[k] = 0;
        tmpl_cells[k]  = 0;
      end
      foreach (sizes[k]) sizes[k] = 7'd1;
      errors = 0;
    endfunction

    function void set_size(logic [1:0] idx, logic [6:0] val);
      sizes[idx] = val;
    endfunction

    // A size of zero counts as one, anything above the store counts as the store.
    function int used_size(logic [6:0] raw);
      if (raw == 7'd0) return 1;
      if (raw > STORE_DIM) return STORE_DIM;
      return int'(raw);
    endfunction

    // Raster-order walk; a strict less-than keeps the first of equal sums.
    function match_t best_placement();
      match_t m;
      int     ir, ic, tr, tc;
      longint sum, diff;
      bit     have;
      m    = '0;
      have = 1'b0;
      ir   = used_size(sizes[REG_IMAGE_ROWS]);
      ic   = used_size(sizes[REG_IMAGE_COLS]);
      tr   = used_size(sizes[REG_TMPL_ROWS]);
      tc   = used_size(sizes[REG_TMPL_COLS]);
      if (tr <= ir && tc <= ic) begin
        for (int i = 0; i + tr <= ir; i++) begin
          for (int j = 0; j + tc <= ic; j++) begin
            sum = 0;
            for (int x = 0; x < tr; x++) begin
              for (int y = 0; y < tc; y++) begin
                diff = longint'(image_cells[(i + x) * STORE_DIM + j + y])
                     - longint'(tmpl_cells[x * STORE_DIM + y]);
                sum += (diff < 0) ? -diff : diff;
              end
            end
            if (sum > longint'(SadMax)) sum = longint'(SadMax);
            if (!have || sum < longint'(m.sad)) begin
              have  = 1'b1;
              m.sad = sum[SadW-1:0];
              m.row = i[5:0];
              m.col = j[5:0];
            end
          end
        end
      end
      m.found = have;
      return m;
    endfunction

    function void note_item(elem_item_t it);
      case (it.req)
        REQ_IMAGE:  image_cells[{it.row, it.col}] = it.value;
        REQ_TMPL:   tmpl_cells[{it.row, it.col}]  = it.value;
        REQ_SEARCH: pending_matches.push_back(best_placement());
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction

    function void compare_field(string fname, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_match(match_t got);
      match_t want;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, found %0d row %0d col %0d sad %0d",
                 $time, got.found, got.row, got.col, got.sad);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("best_row", want.row, got.row);
      compare_field("best_col", want.col, got.col);
      compare_field("best_sad", want.sad, got.sad);
    endfunction
  endclass

  match_checker board;

  // Cells that the stimulus has written so far; a search never reads any other.
  bit image_written [STORE_CELLS];
  bit tmpl_written  [STORE_CELLS];

  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;

  function automatic void push_item(ref elem_item_t q[$], input logic [1:0] req,
                                    input int r, input int c, input int v);
    elem_item_t it;
    it.req   = req;
    it.row   = r[5:0];
    it.col   = c[5:0];
    it.value = v[15:0];
    if (req == REQ_IMAGE) image_written[{it.row, it.col}] = 1'b1;
    else if (req == REQ_TMPL) tmpl_written[{it.row, it.col}] = 1'b1;
    q.push_back(it);
  endfunction

  function automatic int pick_value(int mode);
    if (mode == 2) return int'($urandom_range(0, 3));
    if (mode == 3) begin
      case ($urandom_range(0, 3))
        0: return -32768;
        1: return 32767;
        2: return 0;
        default: return -1;
      endcase
    end
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random write anywhere in either store, or a request the block drops.
  function automatic void push_noise(ref elem_item_t q[$], input int mode);
    if ($urandom_range(0, 1) == 0)
      push_item(q, REQ_UNKNOWN, $urandom_range(0, 63), $urandom_range(0, 63), pick_value(0));
    else
      push_item(q, $urandom_range(0, 1) ? REQ_IMAGE : REQ_TMPL,
                $urandom_range(0, 63), $urandom_range(0, 63), pick_value(mode));
  endfunction

  function automatic logic [6:0] raw_size(int v);
    if (v == 1 && $urandom_range(0, 2) == 0) return 7'd0;
    if (v == STORE_DIM && $urandom_range(0, 1) == 0) return 7'($urandom_range(65, 127));
    return 7'(v);
  endfunction

  // One random phase: sizes, loads for every unwritten cell a search will read, then a mix of
  // searches, rewrites inside the regions in use, stray writes and dropped requests.
  function automatic void build_phase(output logic [6:0] sz [4], ref elem_item_t q[$],
                                      input bit pressure);
    int ir, ic, tr, tc, kind, vmode, n, op;
    bit fits;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      ir = STORE_DIM;
      ic = $urandom_range(1, 2);
      tr = $urandom_range(1, STORE_DIM);
      tc = $urandom_range(1, ic);
    end else if (kind == 1) begin
      ic = STORE_DIM;
      ir = $urandom_range(1, 2);
      tc = $urandom_range(1, STORE_DIM);
      tr = $urandom_range(1, ir);
    end else begin
      ir = $urandom_range(1, 8);
      ic = $urandom_range(1, 8);
      tr = $urandom_range(1, ir + 1);
      tc = $urandom_range(1, ic + 1);
    end
    sz[REG_IMAGE_ROWS] = raw_size(ir);
    sz[REG_IMAGE_COLS] = raw_size(ic);
    sz[REG_TMPL_ROWS]  = raw_size(tr);
    sz[REG_TMPL_COLS]  = raw_size(tc);
    fits  = (tr <= ir) && (tc <= ic);
    vmode = $urandom_range(0, 3);

    if (fits) begin
      for (int r = 0; r < ir; r++)
        for (int c = 0; c < ic; c++)
          if (!image_written[r * STORE_DIM + c]) begin
            if ($urandom_range(0, 9) == 0) push_noise(q, vmode);
            push_item(q, REQ_IMAGE, r, c, pick_value(vmode));
          end
      for (int r = 0; r < tr; r++)
        for (int c = 0; c < tc; c++)
          if (!tmpl_written[r * STORE_DIM + c]) begin
            if ($urandom_range(0, 9) == 0) push_noise(q, vmode);
            push_item(q, REQ_TMPL, r, c, pick_value(vmode));
          end
    end

    n = $urandom_range(6, 30);
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(0, 99);
      if (op < 30)
        push_item(q, REQ_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), pick_value(0));
      else if (op < 55)
        push_item(q, REQ_IMAGE, $urandom_range(0, ir - 1), $urandom_range(0, ic - 1),
                  pick_value(vmode));
      else if (op < 75)
        push_item(q, REQ_TMPL, $urandom_range(0, tr - 1), $urandom_range(0, tc - 1),
                  pick_value(vmode));
      else
        push_noise(q, vmode);
    end
    // Searches at the end of a held-off phase fill the result register and stall the input.
    if (pressure) begin
      push_item(q, REQ_SEARCH, 0, 0, 0);
      push_item(q, REQ_SEARCH, 63, 63, -1);
    end
  endfunction

  task automatic apply_sizes(input logic [6:0] sz [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= sz[i];
      board.set_size(2'(i), sz[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one item in bursts with random gaps; returns at the falling edge after acceptance.
  task automatic send_item(input elem_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req;
    s_axis_tdata  <= {4'b0, it.value, it.col, it.row};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(it);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic run_phase(input logic [6:0] sz [4], input elem_item_t q[$], input bit pressure);
    apply_sizes(sz);
    if (pressure) hold_req = 1'b1;
    foreach (q[k]) send_item(q[k]);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    // Writes give no result, so let the last of them leave the block before any resize.
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    match_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tuser;
      got.row   = m_axis_tdata[5:0];
      got.col   = m_axis_tdata[11:6];
      got.sad   = m_axis_tdata[39:12];
      board.check_match(got);
    end
  end

  // Result side: ready patterns that change every so often, plus one long hold on request.
  initial begin : result_sink
    int unsigned mode, left;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 128);
        end
        left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (left % 8 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    elem_item_t  items [$];
    logic [6:0]  sz [4];
    int unsigned phase_no, random_items;
    bit          pressure;
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-cell sizes: value extremes, the corner cell of both stores, a dropped request.
    sz = '{7'd1, 7'd1, 7'd1, 7'd1};
    push_item(items, REQ_IMAGE, 0, 0, 32767);
    push_item(items, REQ_TMPL, 0, 0, -32768);
    push_item(items, REQ_SEARCH, 0, 0, 0);
    push_item(items, REQ_IMAGE, 63, 63, -1);
    push_item(items, REQ_TMPL, 63, 63, 0);
    push_item(items, REQ_UNKNOWN, 63, 63, -1);
    push_item(items, REQ_TMPL, 0, 0, 32767);
    push_item(items, REQ_SEARCH, 63, 63, -1);
    run_phase(sz, items, 1'b0);

    // Zero and oversized register values; the template is too tall to fit anywhere.
    items.delete();
    sz = '{7'd0, 7'd127, 7'd127, 7'd0};
    push_item(items, REQ_SEARCH, 0, 0, 0);
    run_phase(sz, items, 1'b0);

    // A flat image gives equal sums everywhere, so the first placement must win; one
    // changed cell then moves the best match one column right.
    items.delete();
    sz = '{7'd2, 7'd3, 7'd1, 7'd2};
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        push_item(items, REQ_IMAGE, r, c, 5);
    push_item(items, REQ_TMPL, 0, 0, 5);
    push_item(items, REQ_TMPL, 0, 1, 5);
    push_item(items, REQ_SEARCH, 0, 0, 0);
    push_item(items, REQ_IMAGE, 0, 0, 6);
    push_item(items, REQ_SEARCH, 0, 0, 0);
    run_phase(sz, items, 1'b0);

    phase_no     = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      items.delete();
      pressure = (phase_no % 12 == 3);
      build_phase(sz, items, pressure);
      foreach (items[k])
        if (items[k].req != REQ_UNKNOWN) random_items++;
      run_phase(sz, items, pressure);
      phase_no++;
    end

    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sad_tm_pkg.sv
hw/rtl/sad_tm_store.sv
hw/rtl/sad_tm_walk.sv
hw/rtl/sad_tm_accum.sv
hw/rtl/sad_template_match.sv
hw/rtl/sad_tm_checker.sv
sim/tb_top.sv
